/* src/tcpq_pkg.sv */
// Package for the two-class priority queue with rotation.
// Holds field widths, command, status and register codes, and the item/result structs.
// No dependencies.
`default_nettype none

package tcpq_pkg;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 6;
    localparam int PHASE_W  = 2;
    localparam int WAIT_W   = 8;
    localparam int CFG_W    = 7;
    localparam int CFG_AW   = 1;
    localparam int FQ_DEPTH = 2;

    localparam logic [CFG_AW-1:0]  CFG_PRIMARY   = 1'b0;
    localparam logic [CFG_AW-1:0]  CFG_SECONDARY = 1'b1;
    localparam logic [PHASE_W-1:0] PHASE_LAST    = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_ROTATE  = 2'd1,
        CMD_SERVE   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        KIND_ENQ = 4'b0001,
        KIND_ROT = 4'b0010,
        KIND_SRV = 4'b0100,
        KIND_NOP = 4'b1000
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_QUEUE_FULL = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_UNASSIGNED = 3'd3,
        ST_LOG_FULL   = 3'd4,
        ST_NO_STAFF   = 3'd5
    } status_t;

    typedef struct packed {
        kind_t           kind;
        logic [ID_W-1:0] id;
        logic            urgent;
    } cmd_item_t;

    typedef struct packed {
        status_t            status;
        logic [WAIT_W-1:0]  waiting;
        logic [PHASE_W-1:0] phase;
        logic [IDX_W-1:0]   sidx;
        logic [IDX_W-1:0]   pidx;
        logic [ID_W-1:0]    id;
    } result_t;

endpackage

`default_nettype wire

/* src/two_class_priority_queue_with_rotation.sv */
// Two-class priority queue with staff rotation: top level joining front end and back end.
// Results pass the front-end slot register, then the result register, plus the registered
// RAM read for a successful serve. Throughput: 1 word per cycle for enqueue and rotate while
// results are taken; a successful serve blocks the next word until the RAM read is done.
// Reset: aresetn clears counters, pointers, counts and valids; RAM contents are not cleared.
// Depends on tcpq_pkg, tcpq_front, tcpq_back, tcpq_ram.
`default_nettype none

module two_class_priority_queue_with_rotation #(
    parameter int QUEUE_DEPTH = 128,
    parameter int LOG_DEPTH   = 128,
    parameter int STAFF_MAX   = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [tcpq_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [tcpq_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // item_id
    input  wire logic [2:0]  s_tuser,   // command[1:0], urgent[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // served_id[15:0], primary_index[21:16],
                                        // secondary_index[27:22], phase[29:28],
                                        // waiting_count[37:30], zero[39:38]
    output logic [2:0]       m_tuser    // status
);
    import tcpq_pkg::*;

    localparam logic [WAIT_W-1:0] FULL_WAIT = WAIT_W'(QUEUE_DEPTH);

    logic      q_valid, q_ready;
    cmd_item_t q_item;
    result_t   out_res;

    tcpq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_id     (s_tdata),
        .s_cmd    (s_tuser[1:0]),
        .s_urgent (s_tuser[2]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    tcpq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LOG_DEPTH   (LOG_DEPTH),
        .STAFF_MAX   (STAFF_MAX)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {2'b00, out_res.waiting, out_res.phase, out_res.sidx,
                      out_res.pidx, out_res.id};
    assign m_tuser = out_res.status;

`ifndef SYNTHESIS
    a_full_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res.status == ST_QUEUE_FULL |-> out_res.waiting == FULL_WAIT)
        else $error("queue full reported with wrong waiting count");

    a_empty_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res.status == ST_EMPTY |-> out_res.waiting == '0)
        else $error("queue empty reported with nonzero waiting count");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res.status != ST_OK |->
            out_res.id == '0 && out_res.pidx == '0 && out_res.sidx == '0 &&
            out_res.phase == '0)
        else $error("failed command carries nonzero result fields");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

/* src/tcpq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module tcpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/tcpq_front.sv */
// Front end: accepts input words, decodes the command kind, and buffers them
// in a two-entry queue for the back end. Depends on tcpq_pkg.
`default_nettype none

module tcpq_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [tcpq_pkg::ID_W-1:0] s_id,
    input  wire logic [tcpq_pkg::CMD_W-1:0] s_cmd,
    input  wire logic                      s_urgent,
    output logic                           q_valid,
    input  wire logic                      q_ready,
    output tcpq_pkg::cmd_item_t            q_item
);
    import tcpq_pkg::*;

    localparam int PW = $clog2(FQ_DEPTH);
    localparam int CW = $clog2(FQ_DEPTH + 1);

    cmd_item_t     slot_reg [FQ_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    cmd_item_t     item_in;
    logic          push, pop;

    always_comb begin
        case (cmd_t'(s_cmd))
            CMD_ENQUEUE: item_in.kind = KIND_ENQ;
            CMD_ROTATE:  item_in.kind = KIND_ROT;
            CMD_SERVE:   item_in.kind = KIND_SRV;
            default:     item_in.kind = KIND_NOP;
        endcase
        item_in.id     = s_id;
        item_in.urgent = s_urgent;
    end

    assign s_tready = (cnt_reg != CW'(FQ_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = slot_reg[rptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

/* src/tcpq_back.sv */
// Back end: executes enqueue, rotate and serve against two FIFO regions in one RAM,
// holds the configuration registers and the result register. Depends on tcpq_pkg, tcpq_ram.
`default_nettype none

module tcpq_back #(
    parameter int QUEUE_DEPTH = 128,
    parameter int LOG_DEPTH   = 128,
    parameter int STAFF_MAX   = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [tcpq_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [tcpq_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    input  wire tcpq_pkg::cmd_item_t        q_item,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output tcpq_pkg::result_t               out_res
);
    import tcpq_pkg::*;

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int RAW  = $clog2(2 * QUEUE_DEPTH);
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);
    localparam int LW   = $clog2(LOG_DEPTH + 1);
    localparam int PW   = (STAFF_MAX > 1) ? $clog2(STAFF_MAX) : 1;
    localparam int CW   = $clog2(STAFF_MAX + 1);
    localparam int CNTW = (CW > CFG_W) ? CW : CFG_W;
    localparam int FXW  = (FW > WAIT_W) ? FW : WAIT_W;

    typedef enum logic [1:0] {
        BK_EXEC  = 2'b01,
        BK_FETCH = 2'b10
    } bk_state_t;

    bk_state_t        state_reg, state_next;
    logic [CFG_W-1:0] pcount_reg, scount_reg;
    logic [AW-1:0]    uhead_reg, uhead_next, utail_reg, utail_next;
    logic [AW-1:0]    nhead_reg, nhead_next, ntail_reg, ntail_next;
    logic [FW-1:0]    ucnt_reg, ucnt_next, fill_reg, fill_next;
    logic [LW-1:0]    log_fill_reg, log_fill_next;
    logic [PW-1:0]    pptr_reg, pptr_next, sptr_reg, sptr_next;
    logic             assigned_reg, assigned_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic [CNTW-1:0]  pc, sc, pinc, sinc;
    logic             ram_we, ram_re;
    logic [RAW-1:0]   ram_waddr, ram_raddr;
    logic [ID_W-1:0]  ram_rdata;
    logic             go;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        adv = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [WAIT_W-1:0] wait_out(input logic [FW-1:0] f);
        logic [FXW-1:0] x;
        x = FXW'(f);
        wait_out = x[WAIT_W-1:0];
    endfunction

    tcpq_ram #(
        .WIDTH (ID_W),
        .DEPTH (2 * QUEUE_DEPTH)
    ) u_wait_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_item.id),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_ready   = (state_reg == BK_EXEC) && (!out_valid_reg || out_ready);
    assign go        = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb begin
        pc = (CNTW'(pcount_reg) > CNTW'(STAFF_MAX)) ? CNTW'(STAFF_MAX) : CNTW'(pcount_reg);
        sc = (CNTW'(scount_reg) > CNTW'(STAFF_MAX)) ? CNTW'(STAFF_MAX) : CNTW'(scount_reg);
        pinc = CNTW'(pptr_reg) + 1'b1;
        sinc = CNTW'(sptr_reg) + 1'b1;
    end

    always_comb begin
        state_next     = state_reg;
        uhead_next     = uhead_reg;
        utail_next     = utail_reg;
        nhead_next     = nhead_reg;
        ntail_next     = ntail_reg;
        ucnt_next      = ucnt_reg;
        fill_next      = fill_reg;
        log_fill_next  = log_fill_reg;
        pptr_next      = pptr_reg;
        sptr_next      = sptr_reg;
        assigned_next  = assigned_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = RAW'(utail_reg);
        ram_raddr      = RAW'(uhead_reg);

        case (state_reg)
            BK_EXEC: begin
                if (go) begin
                    out_next        = '0;
                    out_next.status = ST_OK;
                    out_valid_next  = 1'b1;
                    case (q_item.kind)
                        KIND_ENQ: begin
                            if (fill_reg == FW'(QUEUE_DEPTH)) begin
                                out_next.status = ST_QUEUE_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                                if (q_item.urgent) begin
                                    ram_waddr  = RAW'(utail_reg);
                                    utail_next = adv(utail_reg);
                                    ucnt_next  = ucnt_reg + 1'b1;
                                end else begin
                                    ram_waddr  = RAW'(QUEUE_DEPTH) + RAW'(ntail_reg);
                                    ntail_next = adv(ntail_reg);
                                end
                            end
                        end
                        KIND_ROT: begin
                            if (pc == '0 || sc == '0) begin
                                out_next.status = ST_NO_STAFF;
                            end else begin
                                if (assigned_reg) begin
                                    pptr_next = (pinc >= pc) ? '0 : PW'(pinc);
                                    sptr_next = (sinc >= sc) ? '0 : PW'(sinc);
                                end else begin
                                    pptr_next = '0;
                                    sptr_next = '0;
                                end
                                assigned_next  = 1'b1;
                                out_next.phase = phase_reg;
                                phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
                                out_next.pidx  = IDX_W'(CNTW'(pptr_next));
                                out_next.sidx  = IDX_W'(CNTW'(sptr_next));
                            end
                        end
                        KIND_SRV: begin
                            if (fill_reg == '0) begin
                                out_next.status = ST_EMPTY;
                            end else if (!assigned_reg) begin
                                out_next.status = ST_UNASSIGNED;
                            end else if (log_fill_reg == LW'(LOG_DEPTH)) begin
                                out_next.status = ST_LOG_FULL;
                            end else begin
                                ram_re = 1'b1;
                                if (ucnt_reg != '0) begin
                                    ram_raddr  = RAW'(uhead_reg);
                                    uhead_next = adv(uhead_reg);
                                    ucnt_next  = ucnt_reg - 1'b1;
                                end else begin
                                    ram_raddr  = RAW'(QUEUE_DEPTH) + RAW'(nhead_reg);
                                    nhead_next = adv(nhead_reg);
                                end
                                fill_next      = fill_reg - 1'b1;
                                log_fill_next  = log_fill_reg + 1'b1;
                                out_next.pidx  = IDX_W'(CNTW'(pptr_reg));
                                out_valid_next = 1'b0;
                                state_next     = BK_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                    out_next.waiting = wait_out(fill_next);
                end
            end
            BK_FETCH: begin
                out_next.id    = ram_rdata;
                out_valid_next = 1'b1;
                state_next     = BK_EXEC;
            end
            default: begin
                state_next = BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_EXEC;
            pcount_reg    <= '0;
            scount_reg    <= '0;
            uhead_reg     <= '0;
            utail_reg     <= '0;
            nhead_reg     <= '0;
            ntail_reg     <= '0;
            ucnt_reg      <= '0;
            fill_reg      <= '0;
            log_fill_reg  <= '0;
            pptr_reg      <= '0;
            sptr_reg      <= '0;
            assigned_reg  <= 1'b0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            uhead_reg     <= uhead_next;
            utail_reg     <= utail_next;
            nhead_reg     <= nhead_next;
            ntail_reg     <= ntail_next;
            ucnt_reg      <= ucnt_next;
            fill_reg      <= fill_next;
            log_fill_reg  <= log_fill_next;
            pptr_reg      <= pptr_next;
            sptr_reg      <= sptr_next;
            assigned_reg  <= assigned_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_addr == CFG_PRIMARY) begin
                pcount_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == CFG_SECONDARY) begin
                scount_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire
